>>> rtl/alet_pkg.sv
// Shared types and constants for the adjacency list edge table.
// Holds field widths, register indexes, operation and status codes, sequencer states.
// No dependencies; compile first.
`default_nettype none

package alet_pkg;

    // Fixed field widths of the item, result and configuration port
    localparam int VERTEX_BITS       = 6;
    localparam int EDGE_WEIGHT_BITS  = 32;
    localparam int STATUS_BITS       = 2;
    localparam int VERTEX_COUNT_BITS = 7;
    localparam int DEGREE_LIMIT_BITS = 4;
    localparam int CFG_DATA_BITS     = 7;
    localparam int CFG_INDEX_BITS    = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 8;
    localparam int DEF_WEIGHT_BITS  = 32;

    // Register values after reset
    localparam logic [VERTEX_COUNT_BITS-1:0] VERTEX_COUNT_RESET = 7'd64;
    localparam logic [DEGREE_LIMIT_BITS-1:0] DEGREE_LIMIT_RESET = 4'd8;
    localparam logic                         WEIGHTED_RESET     = 1'b0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_VERTEX_COUNT = 2'd0,
        CFG_DEGREE_LIMIT = 2'd1,
        CFG_WEIGHTED     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_RANGE   = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_INS_DEG_A,
        ST_INS_DEG_B,
        ST_INS_DECIDE,
        ST_INS_APP_A,
        ST_INS_APP_B,
        ST_REM_DEG,
        ST_REM_LOAD,
        ST_REM_SCAN,
        ST_REM_MOVE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/alet_req_if.sv
// Request channel of the edge table: one edge insert or remove per beat.
// Depends on alet_pkg for field widths.
`default_nettype none

interface alet_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic [alet_pkg::VERTEX_BITS-1:0]       origin_vertex;
    logic [alet_pkg::VERTEX_BITS-1:0]       dest_vertex;
    logic                                   one_way;
    logic [alet_pkg::EDGE_WEIGHT_BITS-1:0]  edge_weight;

    modport source (
        output valid, kind, origin_vertex, dest_vertex, one_way, edge_weight,
        input  ready
    );

    modport sink (
        input  valid, kind, origin_vertex, dest_vertex, one_way, edge_weight,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/alet_rsp_if.sv
// Response channel of the edge table: one status word per beat.
// Depends on alet_pkg for the status width.
`default_nettype none

interface alet_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [alet_pkg::STATUS_BITS-1:0]  status;

    modport source (
        output valid, status,
        input  ready
    );

    modport sink (
        input  valid, status,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/alet_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module alet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/adjacency_list_edge_table_core.sv
// Bounded-degree adjacency table: per-vertex neighbour lists, optional weights, degree counts.
// Depends on alet_pkg, alet_req_if, alet_rsp_if and alet_ram.
//
// One request beat inserts or removes an edge (and its mirror unless one_way is set);
// exactly one status beat comes back for each. After reset the block sweeps every degree
// memory entry to zero and takes no request meanwhile; configuration writes are taken at
// any time. The block works on one request at a time and is not ready until it finishes.
// An insert checks the range, reads both degree counts, decides, then appends to the
// origin's list and, unless one-way, to the destination's; an insert refused for a full
// list ends after the decision, and a request with a vertex out of range ends at the
// range check. A remove reads the degree count and walks the list one neighbour-memory
// read a cycle until a match or the list's end; on a match it moves the last entry into
// the hole and shortens the list, and a mirrored remove then searches the destination's
// list likewise. A finished status waits in an output register, so the next request may
// be taken while the previous status is still unclaimed; a later request holds in its
// finishing state for as long as that earlier status stays unclaimed.
`default_nettype none

module adjacency_list_edge_table_core #(
    parameter int MAX_VERTICES = alet_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = alet_pkg::DEF_MAX_DEGREE,
    parameter int WEIGHT_BITS  = alet_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [alet_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [alet_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    alet_req_if.sink                                 req,
    alet_rsp_if.source                               rsp
);

    localparam int SLOTS   = MAX_VERTICES * MAX_DEGREE;
    localparam int VW      = $clog2(MAX_VERTICES);
    localparam int SW      = $clog2(SLOTS);
    localparam int DW      = $clog2(MAX_DEGREE + 1);
    localparam int NVW     = $clog2(MAX_VERTICES + 1);
    localparam int CMPW    = (NVW > alet_pkg::VERTEX_COUNT_BITS) ? NVW
                                                                : alet_pkg::VERTEX_COUNT_BITS;
    localparam int LW      = ((DW > alet_pkg::DEGREE_LIMIT_BITS) ? DW
                                                                 : alet_pkg::DEGREE_LIMIT_BITS) + 1;

    // Sequencer and configuration
    alet_pkg::state_t                          state_reg, state_next;
    logic [VW-1:0]                             clr_idx_reg, clr_idx_next;
    logic [alet_pkg::VERTEX_COUNT_BITS-1:0]    vertex_count_reg;
    logic [alet_pkg::DEGREE_LIMIT_BITS-1:0]    degree_limit_reg;
    logic                                      weighted_reg;
    logic                                      pass_reg, pass_next;
    logic                                      rsp_valid_reg, rsp_valid_next;

    // Latched request and working values
    logic                                      kind_reg, kind_next;
    logic [alet_pkg::VERTEX_BITS-1:0]          org_reg, org_next;
    logic [alet_pkg::VERTEX_BITS-1:0]          dst_reg, dst_next;
    logic                                      one_way_reg, one_way_next;
    logic [alet_pkg::EDGE_WEIGHT_BITS-1:0]     weight_reg, weight_next;
    logic [DW-1:0]                             cnt_a_reg, cnt_a_next;
    logic [DW-1:0]                             cnt_b_reg, cnt_b_next;
    logic [DW-1:0]                             n_reg, n_next;
    logic [DW-1:0]                             i_reg, i_next;
    alet_pkg::status_t                         status_reg, status_next;
    logic [alet_pkg::STATUS_BITS-1:0]          rsp_status_reg;

    // Memory ports
    logic                    deg_we;
    logic [VW-1:0]           deg_waddr, deg_raddr;
    logic [DW-1:0]           deg_wdata, deg_rdata;
    logic                    nb_we;
    logic [SW-1:0]           nb_waddr, nb_raddr;
    logic [alet_pkg::VERTEX_BITS-1:0] nb_wdata, nb_rdata;
    logic                    wt_we;
    logic [WEIGHT_BITS-1:0]  wt_wdata, wt_rdata;

    // Decode helpers
    logic [CMPW-1:0]         vc_ext, nv_eff;
    logic                    range_bad;
    logic [LW-1:0]           dl_ext, lim_eff, cnt_a_l, cnt_b_l;
    logic                    self_pair, list_full;
    logic [VW-1:0]           a_idx, b_idx, pass_v;
    logic [alet_pkg::VERTEX_BITS-1:0] pass_nb;
    logic                    pass_done, pass_found;
    logic                    rsp_load;

    function automatic logic [SW-1:0] slot_addr(input logic [VW-1:0] v,
                                                input logic [DW-1:0] j);
        slot_addr = SW'(v) * SW'(MAX_DEGREE) + SW'(j);
    endfunction

    alet_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_deg_ram (
        .clk     (clk),
        .wr_en   (deg_we),
        .wr_addr (deg_waddr),
        .wr_data (deg_wdata),
        .rd_addr (deg_raddr),
        .rd_data (deg_rdata)
    );

    alet_ram #(
        .WIDTH (alet_pkg::VERTEX_BITS),
        .DEPTH (SLOTS)
    ) u_nb_ram (
        .clk     (clk),
        .wr_en   (nb_we),
        .wr_addr (nb_waddr),
        .wr_data (nb_wdata),
        .rd_addr (nb_raddr),
        .rd_data (nb_rdata)
    );

    alet_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (SLOTS)
    ) u_wt_ram (
        .clk     (clk),
        .wr_en   (wt_we),
        .wr_addr (nb_waddr),
        .wr_data (wt_wdata),
        .rd_addr (nb_raddr),
        .rd_data (wt_rdata)
    );

    // Effective vertex count and degree limit, clamped to the built sizes
    assign vc_ext    = CMPW'(vertex_count_reg);
    assign nv_eff    = (vc_ext > CMPW'(MAX_VERTICES)) ? CMPW'(MAX_VERTICES) : vc_ext;
    assign range_bad = (CMPW'(org_reg) >= nv_eff) || (CMPW'(dst_reg) >= nv_eff);

    assign dl_ext    = LW'(degree_limit_reg);
    assign lim_eff   = (dl_ext > LW'(MAX_DEGREE)) ? LW'(MAX_DEGREE) : dl_ext;
    assign cnt_a_l   = LW'(cnt_a_reg);
    assign cnt_b_l   = LW'(cnt_b_reg);
    assign self_pair = !one_way_reg && (org_reg == dst_reg);

    always_comb
    begin
        if (one_way_reg)
        begin
            list_full = (cnt_a_l >= lim_eff);
        end
        else if (self_pair)
        begin
            list_full = ((cnt_a_l + LW'(2)) > lim_eff);
        end
        else
        begin
            list_full = (cnt_a_l >= lim_eff) || (cnt_b_l >= lim_eff);
        end
    end

    assign a_idx   = VW'(org_reg);
    assign b_idx   = VW'(dst_reg);
    assign pass_v  = pass_reg ? b_idx : a_idx;
    assign pass_nb = pass_reg ? org_reg : dst_reg;

    assign rsp_load = (state_reg == alet_pkg::ST_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        pass_next    = pass_reg;
        kind_next    = kind_reg;
        org_next     = org_reg;
        dst_next     = dst_reg;
        one_way_next = one_way_reg;
        weight_next  = weight_reg;
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        status_next  = status_reg;
        deg_we       = 1'b0;
        deg_waddr    = a_idx;
        deg_wdata    = '0;
        deg_raddr    = a_idx;
        nb_we        = 1'b0;
        nb_waddr     = '0;
        nb_wdata     = '0;
        nb_raddr     = '0;
        wt_we        = 1'b0;
        wt_wdata     = WEIGHT_BITS'(weight_reg);
        pass_done    = 1'b0;
        pass_found   = 1'b0;

        unique case (state_reg)
            alet_pkg::ST_CLEAR:
            begin
                deg_we    = 1'b1;
                deg_waddr = clr_idx_reg;
                if (clr_idx_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = alet_pkg::ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            alet_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next    = req.kind;
                    org_next     = req.origin_vertex;
                    dst_next     = req.dest_vertex;
                    one_way_next = req.one_way;
                    weight_next  = req.edge_weight;
                    state_next   = alet_pkg::ST_CHECK;
                end
            end

            alet_pkg::ST_CHECK:
            begin
                if (range_bad)
                begin
                    status_next = alet_pkg::STATUS_RANGE;
                    state_next  = alet_pkg::ST_DONE;
                end
                else if (kind_reg == alet_pkg::KIND_INSERT)
                begin
                    deg_raddr  = a_idx;
                    state_next = alet_pkg::ST_INS_DEG_A;
                end
                else
                begin
                    pass_next  = 1'b0;
                    state_next = alet_pkg::ST_REM_DEG;
                end
            end

            alet_pkg::ST_INS_DEG_A:
            begin
                cnt_a_next = deg_rdata;
                deg_raddr  = b_idx;
                state_next = alet_pkg::ST_INS_DEG_B;
            end

            alet_pkg::ST_INS_DEG_B:
            begin
                cnt_b_next = deg_rdata;
                state_next = alet_pkg::ST_INS_DECIDE;
            end

            alet_pkg::ST_INS_DECIDE:
            begin
                if (list_full)
                begin
                    status_next = alet_pkg::STATUS_FULL;
                    state_next  = alet_pkg::ST_DONE;
                end
                else
                begin
                    // A mirrored self loop lands twice in one list: second slot follows the first
                    if (self_pair)
                    begin
                        cnt_b_next = cnt_a_reg + 1'b1;
                    end
                    state_next = alet_pkg::ST_INS_APP_A;
                end
            end

            alet_pkg::ST_INS_APP_A:
            begin
                nb_we     = 1'b1;
                nb_waddr  = slot_addr(a_idx, cnt_a_reg);
                nb_wdata  = dst_reg;
                wt_we     = weighted_reg;
                deg_we    = 1'b1;
                deg_waddr = a_idx;
                deg_wdata = cnt_a_reg + 1'b1;
                if (one_way_reg)
                begin
                    status_next = alet_pkg::STATUS_DONE;
                    state_next  = alet_pkg::ST_DONE;
                end
                else
                begin
                    state_next = alet_pkg::ST_INS_APP_B;
                end
            end

            alet_pkg::ST_INS_APP_B:
            begin
                nb_we       = 1'b1;
                nb_waddr    = slot_addr(b_idx, cnt_b_reg);
                nb_wdata    = org_reg;
                wt_we       = weighted_reg;
                deg_we      = 1'b1;
                deg_waddr   = b_idx;
                deg_wdata   = cnt_b_reg + 1'b1;
                status_next = alet_pkg::STATUS_DONE;
                state_next  = alet_pkg::ST_DONE;
            end

            alet_pkg::ST_REM_DEG:
            begin
                deg_raddr  = pass_v;
                state_next = alet_pkg::ST_REM_LOAD;
            end

            alet_pkg::ST_REM_LOAD:
            begin
                n_next = deg_rdata;
                i_next = '0;
                if (deg_rdata == '0)
                begin
                    pass_done = 1'b1;
                end
                else
                begin
                    nb_raddr   = slot_addr(pass_v, '0);
                    state_next = alet_pkg::ST_REM_SCAN;
                end
            end

            alet_pkg::ST_REM_SCAN:
            begin
                // Read data belongs to entry i; fetch entry i+1 ahead unless this one matches
                if (nb_rdata == pass_nb)
                begin
                    nb_raddr   = slot_addr(pass_v, n_reg - 1'b1);
                    state_next = alet_pkg::ST_REM_MOVE;
                end
                else if ((i_reg + 1'b1) == n_reg)
                begin
                    pass_done = 1'b1;
                end
                else
                begin
                    i_next   = i_reg + 1'b1;
                    nb_raddr = slot_addr(pass_v, i_reg + 1'b1);
                end
            end

            alet_pkg::ST_REM_MOVE:
            begin
                // Move the last entry into the hole and shorten the list
                nb_we      = 1'b1;
                nb_waddr   = slot_addr(pass_v, i_reg);
                nb_wdata   = nb_rdata;
                wt_we      = weighted_reg;
                wt_wdata   = wt_rdata;
                deg_we     = 1'b1;
                deg_waddr  = pass_v;
                deg_wdata  = n_reg - 1'b1;
                pass_done  = 1'b1;
                pass_found = 1'b1;
            end

            alet_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = alet_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = alet_pkg::ST_IDLE;
            end
        endcase

        // End of one list pass of a remove; a missing reverse edge is not an error
        if (pass_done)
        begin
            if (pass_reg)
            begin
                status_next = alet_pkg::STATUS_DONE;
                state_next  = alet_pkg::ST_DONE;
            end
            else if (!pass_found)
            begin
                status_next = alet_pkg::STATUS_MISSING;
                state_next  = alet_pkg::ST_DONE;
            end
            else if (one_way_reg)
            begin
                status_next = alet_pkg::STATUS_DONE;
                state_next  = alet_pkg::ST_DONE;
            end
            else
            begin
                pass_next  = 1'b1;
                state_next = alet_pkg::ST_REM_DEG;
            end
        end
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= alet_pkg::ST_CLEAR;
            clr_idx_reg      <= '0;
            pass_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            vertex_count_reg <= alet_pkg::VERTEX_COUNT_RESET;
            degree_limit_reg <= alet_pkg::DEGREE_LIMIT_RESET;
            weighted_reg     <= alet_pkg::WEIGHTED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            pass_reg      <= pass_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    alet_pkg::CFG_VERTEX_COUNT:
                    begin
                        vertex_count_reg <= cfg_data[alet_pkg::VERTEX_COUNT_BITS-1:0];
                    end
                    alet_pkg::CFG_DEGREE_LIMIT:
                    begin
                        degree_limit_reg <= cfg_data[alet_pkg::DEGREE_LIMIT_BITS-1:0];
                    end
                    alet_pkg::CFG_WEIGHTED:
                    begin
                        weighted_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        org_reg     <= org_next;
        dst_reg     <= dst_next;
        one_way_reg <= one_way_next;
        weight_reg  <= weight_next;
        cnt_a_reg   <= cnt_a_next;
        cnt_b_reg   <= cnt_b_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        status_reg  <= status_next;
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
        end
    end

    assign req.ready  = (state_reg == alet_pkg::ST_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;

    // A degree count never grows past the list size
    a_deg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        deg_we |-> (deg_wdata <= DW'(MAX_DEGREE)))
        else $error("degree count written beyond MAX_DEGREE");

    // An append only happens below the effective limit
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alet_pkg::ST_INS_APP_A) |-> (cnt_a_l < lim_eff))
        else $error("append into a full list");

    // The scan index stays inside the list being searched
    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alet_pkg::ST_REM_SCAN) |-> (i_reg < n_reg))
        else $error("scan index past end of list");

    // A new status beat only appears straight after the finishing state
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == alet_pkg::ST_DONE))
        else $error("status raised outside the finishing state");

    // An accepted request always goes to the range check next
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == alet_pkg::ST_CHECK))
        else $error("accepted request did not enter range check");

endmodule

`default_nettype wire
